// ----- src/tlv_varint_deframer_core_defines.svh -----
// ----------------------------------------------------------------------------
// TLV varint deframer assertion macros
// Shared concurrent assertion forms used by the deframer RTL.
// ----------------------------------------------------------------------------
`ifndef TLV_VARINT_DEFRAMER_CORE_DEFINES_SVH
`define TLV_VARINT_DEFRAMER_CORE_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define TLVD_ASSERT_NOW(label, clk, rst_n, cond, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (expr)) \
        else $error("%m: check failed");

// Next-cycle implication, disabled while reset is asserted.
`define TLVD_ASSERT_NEXT(label, clk, rst_n, cond, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (expr)) \
        else $error("%m: check failed");

`endif

// ----- src/tlvd_pkg.sv -----
// ----------------------------------------------------------------------------
// TLV varint deframer package
// Codes, widths and the result record shared by the deframer modules.
// ----------------------------------------------------------------------------
`default_nettype none

package tlvd_pkg;

    // Width of the decoded fields as they leave the block.
    localparam int OUT_W = 16;
    // Bits carried by one varint byte, and the continuation flag.
    localparam int DIGIT_BITS = 7;
    localparam logic [7:0] CONT_FLAG = 8'h80;

    // Parse phases.
    localparam logic [1:0] PH_TYPE   = 2'd0;
    localparam logic [1:0] PH_LENGTH = 2'd1;
    localparam logic [1:0] PH_VALUE  = 2'd2;
    localparam logic [1:0] PH_SKIP   = 2'd3;

    // Result kinds.
    localparam logic [1:0] KIND_EMPTY = 2'd0;
    localparam logic [1:0] KIND_VALUE = 2'd1;
    localparam logic [1:0] KIND_ERROR = 2'd2;

    // One result item plus its presence flag.
    typedef struct packed {
        logic               present;
        logic [1:0]         kind;
        logic [OUT_W-1:0]   rec_type;
        logic [OUT_W-1:0]   rec_length;
        logic [7:0]         value_byte;
        logic               last_of_value;
    } t_result;

endpackage

`default_nettype wire

// ----- src/tlvd_step.sv -----
// ----------------------------------------------------------------------------
// TLV varint deframer step logic
// Combinational next-state and result logic for one input byte.
// ----------------------------------------------------------------------------
`default_nettype none

module tlvd_step
    import tlvd_pkg::*;
#(
    parameter int FIELD_BITS = 16
) (
    input  wire logic [7:0]            i_byte,
    input  wire logic [1:0]            i_phase,
    input  wire logic [FIELD_BITS-1:0] i_accum,
    input  wire logic [FIELD_BITS-1:0] i_held_type,
    input  wire logic [FIELD_BITS-1:0] i_held_length,
    input  wire logic [FIELD_BITS-1:0] i_remaining,
    output logic [1:0]                 o_phase,
    output logic [FIELD_BITS-1:0]      o_accum,
    output logic [FIELD_BITS-1:0]      o_held_type,
    output logic [FIELD_BITS-1:0]      o_held_length,
    output logic [FIELD_BITS-1:0]      o_remaining,
    output t_result                    o_result
);

    logic                  more;
    logic                  overflow;
    logic [FIELD_BITS-1:0] acc_shift;
    logic [FIELD_BITS-1:0] rem_dec;

    // Varint digit shift and overflow test on the top seven accumulator bits.
    assign more      = (i_byte & CONT_FLAG) != 8'h00;
    assign overflow  = i_accum[FIELD_BITS-1 -: DIGIT_BITS] != '0;
    assign acc_shift = (i_accum << DIGIT_BITS) | FIELD_BITS'(i_byte[DIGIT_BITS-1:0]);
    assign rem_dec   = i_remaining - FIELD_BITS'(1);

    // Phase decode.
    always_comb begin
        o_phase       = i_phase;
        o_accum       = i_accum;
        o_held_type   = i_held_type;
        o_held_length = i_held_length;
        o_remaining   = i_remaining;
        o_result      = '0;

        unique case (i_phase)
            PH_TYPE, PH_LENGTH: begin
                if (overflow) begin
                    // The varint does not fit: report it and resynchronize.
                    o_accum          = '0;
                    o_phase          = more ? PH_SKIP : PH_TYPE;
                    o_result.present = 1'b1;
                    o_result.kind    = KIND_ERROR;
                    o_result.rec_type = (i_phase == PH_LENGTH)
                                        ? OUT_W'(i_held_type) : '0;
                end else if (more) begin
                    o_accum = acc_shift;
                end else if (i_phase == PH_TYPE) begin
                    o_held_type = acc_shift;
                    o_accum     = '0;
                    o_phase     = PH_LENGTH;
                end else begin
                    o_held_length = acc_shift;
                    o_accum       = '0;
                    if (acc_shift == '0) begin
                        // A zero-length record gives one header-only result.
                        o_phase                = PH_TYPE;
                        o_result.present       = 1'b1;
                        o_result.kind          = KIND_EMPTY;
                        o_result.rec_type      = OUT_W'(i_held_type);
                        o_result.last_of_value = 1'b1;
                    end else begin
                        o_remaining = acc_shift;
                        o_phase     = PH_VALUE;
                    end
                end
            end
            PH_VALUE: begin
                o_remaining            = rem_dec;
                o_phase                = (rem_dec == '0) ? PH_TYPE : PH_VALUE;
                o_result.present       = 1'b1;
                o_result.kind          = KIND_VALUE;
                o_result.rec_type      = OUT_W'(i_held_type);
                o_result.rec_length    = OUT_W'(i_held_length);
                o_result.value_byte    = i_byte;
                o_result.last_of_value = (rem_dec == '0);
            end
            PH_SKIP: begin
                // Drop the tail of an overflowed varint.
                if (!more) begin
                    o_phase = PH_TYPE;
                end
            end
            default: begin
                o_phase = PH_TYPE;
            end
        endcase
    end

endmodule

`default_nettype wire

// ----- src/tlv_varint_deframer_core.sv -----
// ----------------------------------------------------------------------------
// TLV varint deframer core
// Splits a byte stream of type/length/value records with base-128 varint
// headers into results carrying the record type and length: one per value byte, plus one per empty record or error.
//
//   Channel   Direction   Handshake            Payload
//   input     in          i_valid / o_stall    i_data_byte
//   result    out         o_valid / i_stall    o_kind, o_rec_type, o_rec_length,
//                                              o_value_byte, o_last_of_value
//
// One byte is accepted per clock while o_stall is low.
// The path is one input register followed by the parse logic and one result
// register, so the parse state updates once per byte.
// Reset is synchronous and active low and returns the parser to the type phase.
// A stall on the result side holds the result register and then the input
// register; a transfer can proceed in any cycle where the result moves on.
// ----------------------------------------------------------------------------
`default_nettype none

module tlv_varint_deframer_core
    import tlvd_pkg::*;
#(
    parameter int FIELD_BITS = 16
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_valid,
    output logic                   o_stall,
    input  wire logic [7:0]        i_data_byte,
    output logic                   o_valid,
    input  wire logic              i_stall,
    output logic [1:0]             o_kind,
    output logic [OUT_W-1:0]       o_rec_type,
    output logic [OUT_W-1:0]       o_rec_length,
    output logic [7:0]             o_value_byte,
    output logic                   o_last_of_value
);

`include "tlv_varint_deframer_core_defines.svh"

    logic                  r_in_valid;
    logic [7:0]            r_in_byte;
    logic                  r_out_valid;
    t_result               r_out;
    logic [1:0]            r_phase;
    logic [FIELD_BITS-1:0] r_accum;
    logic [FIELD_BITS-1:0] r_held_type;
    logic [FIELD_BITS-1:0] r_held_length;
    logic [FIELD_BITS-1:0] r_remaining;

    logic [1:0]            n_phase;
    logic [FIELD_BITS-1:0] n_accum;
    logic [FIELD_BITS-1:0] n_held_type;
    logic [FIELD_BITS-1:0] n_held_length;
    logic [FIELD_BITS-1:0] n_remaining;
    t_result               step_res;

    logic                  out_blocked;
    logic                  step_go;
    logic                  in_take;

    // Flow control: the result register frees up when empty or taken.
    assign out_blocked = r_out_valid && i_stall;
    assign step_go     = r_in_valid && !out_blocked;
    assign o_stall     = r_in_valid && out_blocked;
    assign in_take     = i_valid && !o_stall;

    // Parse logic for the byte in the input register.
    tlvd_step #(
        .FIELD_BITS (FIELD_BITS)
    ) u_step (
        .i_byte        (r_in_byte),
        .i_phase       (r_phase),
        .i_accum       (r_accum),
        .i_held_type   (r_held_type),
        .i_held_length (r_held_length),
        .i_remaining   (r_remaining),
        .o_phase       (n_phase),
        .o_accum       (n_accum),
        .o_held_type   (n_held_type),
        .o_held_length (n_held_length),
        .o_remaining   (n_remaining),
        .o_result      (step_res)
    );

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_stall) begin
            r_in_valid <= i_valid;
        end
        if (in_take) begin
            r_in_byte <= i_data_byte;
        end
    end

    // Parse state, updated once per consumed byte.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase       <= PH_TYPE;
            r_accum       <= '0;
            r_held_type   <= '0;
            r_held_length <= '0;
            r_remaining   <= '0;
        end else if (step_go) begin
            r_phase       <= n_phase;
            r_accum       <= n_accum;
            r_held_type   <= n_held_type;
            r_held_length <= n_held_length;
            r_remaining   <= n_remaining;
        end
    end

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (!out_blocked) begin
            r_out_valid <= step_go && step_res.present;
        end
        if (step_go && step_res.present) begin
            r_out <= step_res;
        end
    end

    assign o_valid         = r_out_valid;
    assign o_kind          = r_out.kind;
    assign o_rec_type      = r_out.rec_type;
    assign o_rec_length    = r_out.rec_length;
    assign o_value_byte    = r_out.value_byte;
    assign o_last_of_value = r_out.last_of_value;

    // Value phase is entered only with bytes left to pass.
    `TLVD_ASSERT_NOW(a_value_has_bytes, i_clk, i_rst_n,
        r_phase == PH_VALUE, r_remaining != '0)
    // Only value results carry a payload byte.
    `TLVD_ASSERT_NOW(a_payload_only_on_value, i_clk, i_rst_n,
        o_valid && o_kind != KIND_VALUE, o_value_byte == 8'h00)
    // Error results carry no length and no last flag.
    `TLVD_ASSERT_NOW(a_error_fields_clear, i_clk, i_rst_n,
        o_valid && o_kind == KIND_ERROR, o_rec_length == '0 && !o_last_of_value)
    // Empty records are always marked last.
    `TLVD_ASSERT_NOW(a_empty_is_last, i_clk, i_rst_n,
        o_valid && o_kind == KIND_EMPTY, o_last_of_value)
    // A held input byte is not lost while the result side is blocked.
    `TLVD_ASSERT_NEXT(a_input_held, i_clk, i_rst_n,
        r_in_valid && out_blocked, r_in_valid && $stable(r_in_byte))

endmodule

`default_nettype wire
